### rtl/kst_pkg.sv
// Shared constants, codes and control types for the key slot table.
package kst_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int IDX_W     = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 8;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  localparam logic [KEY_W:0] NUM_SLOTS_K = (KEY_W + 1)'(NUM_SLOTS);

  typedef struct packed {
    logic ready;
    logic capture;
    logic execute;
  } kst_cmd_t;

  typedef struct packed {
    logic out_free;
  } kst_stat_t;

endpackage

### rtl/kst_req_if.sv
// Request channel: valid/ready handshake carrying one table operation.
interface kst_req_if import kst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [KEY_W-1:0]    key;
  logic [DATA_W-1:0]   value;
  logic [DATA_W-1:0]   cleanup_handle;

  modport source (output valid, mode, key, value, cleanup_handle, input ready);
  modport sink   (input valid, mode, key, value, cleanup_handle, output ready);
endinterface

### rtl/kst_rsp_if.sv
// Response channel: valid/ready handshake carrying one operation result.
interface kst_rsp_if import kst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key_out;
  logic [DATA_W-1:0]   value_out;
  logic                run_cleanup;
  logic [DATA_W-1:0]   handle_out;

  modport source (output valid, status, key_out, value_out, run_cleanup, handle_out,
                  input ready);
  modport sink   (input valid, status, key_out, value_out, run_cleanup, handle_out,
                  output ready);
endinterface

### rtl/key_slot_table_core.sv
// Top level of the key slot table: controller, datapath and channel hookup.
//
// Requests arrive on req (valid/ready): mode selects create, set, get or
// delete; key names the slot; value is stored by set; cleanup_handle is
// recorded by create. Each request transaction yields exactly one response
// transaction on rsp carrying status, the allocated key, the value read,
// the cleanup flag and the stored handle; fields a request does not produce
// read as zero.
// The request is registered at capture and the result register is loaded
// at execute, which waits only while an earlier response is still stalled.
// One request is handled at a time: the request is captured with the slot
// read and the lowest-free search, and the table update and result register
// load happen at execute; a new request is accepted only after that.
// The result register frees the request side: a new request is accepted
// while an earlier response still waits. If rsp is stalled when the next
// request is ready to complete, that request holds until the register frees.
// Reset (synchronous, active high) marks all slots free and drops rsp.valid;
// slot storage needs no clearing since a slot is written on create before
// it can be read.
module key_slot_table_core import kst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  kst_req_if.sink   req,
  kst_rsp_if.source rsp
);

  kst_cmd_t  cmd;
  kst_stat_t stat;

  assign req.ready = cmd.ready;

  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  kst_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_mode   (req.mode),
    .req_key    (req.key),
    .req_value  (req.value),
    .req_handle (req.cleanup_handle),
    .rsp        (rsp)
  );

endmodule

### rtl/kst_ctrl.sv
// Controller: sequences capture and execute of one request at a time.
module kst_ctrl import kst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  kst_stat_t stat,
  output kst_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        cmd.ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

### rtl/kst_datapath.sv
// Datapath: slot storage, free-slot search, request and result registers.
module kst_datapath import kst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  kst_cmd_t           cmd,
  output kst_stat_t          stat,
  input  logic [MODE_W-1:0]  req_mode,
  input  logic [KEY_W-1:0]   req_key,
  input  logic [DATA_W-1:0]  req_value,
  input  logic [DATA_W-1:0]  req_handle,
  kst_rsp_if.source          rsp
);

  logic [NUM_SLOTS-1:0] in_use;
  logic [DATA_W-1:0]    value_mem  [NUM_SLOTS];
  logic [DATA_W-1:0]    handle_mem [NUM_SLOTS];

  logic [MODE_W-1:0] op_mode;
  logic [IDX_W-1:0]  op_idx;
  logic [DATA_W-1:0] op_value;
  logic [DATA_W-1:0] op_handle;
  logic              op_key_ok;
  logic [IDX_W-1:0]  free_idx;
  logic              free_any;
  logic [DATA_W-1:0] rd_value;
  logic [DATA_W-1:0] rd_handle;

  logic [NUM_SLOTS-1:0] free_vec;
  logic [NUM_SLOTS-1:0] free_first;
  logic [IDX_W-1:0]     free_enc;
  logic [IDX_W-1:0]     in_idx;
  logic                 in_range;
  logic                 in_key_ok;

  logic              do_create;
  logic              do_set;
  logic              do_delete;
  logic              val_we;
  logic [IDX_W-1:0]  val_addr;
  logic [DATA_W-1:0] val_wdata;

  assign in_idx    = req_key[IDX_W-1:0];
  assign in_range  = {1'b0, req_key} < NUM_SLOTS_K;
  assign in_key_ok = in_range && in_use[in_idx];

  // lowest free slot: isolate lowest set bit, then encode
  assign free_vec   = ~in_use;
  assign free_first = free_vec & (~free_vec + NUM_SLOTS'(1));

  always_comb begin
    free_enc = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (free_first[i]) free_enc = free_enc | IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode   <= req_mode;
      op_idx    <= in_idx;
      op_value  <= req_value;
      op_handle <= req_handle;
      op_key_ok <= in_key_ok;
      free_idx  <= free_enc;
      free_any  <= |free_vec;
      rd_value  <= value_mem[in_idx];
      rd_handle <= handle_mem[in_idx];
    end
  end

  assign do_create = cmd.execute && (op_mode == MODE_CREATE) && free_any;
  assign do_set    = cmd.execute && (op_mode == MODE_SET) && op_key_ok;
  assign do_delete = cmd.execute && (op_mode == MODE_DELETE) && op_key_ok;

  assign val_we    = do_create || do_set;
  assign val_addr  = do_create ? free_idx : op_idx;
  assign val_wdata = do_create ? '0 : op_value;

  always_ff @(posedge clk) begin
    if (val_we)    value_mem[val_addr]  <= val_wdata;
    if (do_create) handle_mem[free_idx] <= op_handle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (do_create) in_use[free_idx] <= 1'b1;
      if (do_delete) in_use[op_idx]   <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.execute) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp.status      <= ST_OK;
      rsp.key_out     <= '0;
      rsp.value_out   <= '0;
      rsp.run_cleanup <= 1'b0;
      rsp.handle_out  <= '0;
      if (op_mode == MODE_CREATE) begin
        if (free_any) rsp.key_out <= KEY_W'(free_idx);
        else          rsp.status  <= ST_FULL;
      end else if (!op_key_ok) begin
        rsp.status <= ST_INVALID;
      end else if (op_mode == MODE_GET) begin
        rsp.value_out <= rd_value;
      end else if (op_mode == MODE_DELETE) begin
        rsp.value_out   <= rd_value;
        rsp.handle_out  <= rd_handle;
        rsp.run_cleanup <= |rd_handle;
      end
    end
  end

  assign stat.out_free = !rsp.valid || rsp.ready;

endmodule
